>>> rtl/sfm_pkg.sv
// shared types and constants for the smallest factorial multiple block
// no dependencies
`default_nettype none
package sfm_pkg;
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_PRIMES  = 16;
	localparam int IDX_W       = $clog2(MAX_PRIMES);
	localparam int CNT_W       = $clog2(MAX_PRIMES + 1);
	localparam int EXP_W       = 5;
	localparam int STEP_W      = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		value_t value;
		logic   trivial;
	} item_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   busy;
		logic   done;
		value_t quot;
		value_t rem;
	} div_rsp_t;

	typedef struct packed {
		logic   valid;
		value_t value;
	} res_t;
endpackage
`default_nettype wire

>>> rtl/sfm_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on sfm_pkg
`default_nettype none
module sfm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sfm_pkg::div_req_t req,
	output sfm_pkg::div_rsp_t      rsp
);
	import sfm_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [STEP_W-1:0]      step_q;
	logic [VALUE_WIDTH:0]   rem_q;
	value_t                 quo_q;
	value_t                 dvs_q;
	logic [VALUE_WIDTH:0]   trial;
	logic                   fits;

	assign trial = {rem_q[VALUE_WIDTH-1:0], quo_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q[VALUE_WIDTH-1:0];
endmodule
`default_nettype wire

>>> rtl/sfm_queue.sv
// front part: accepts words, flags trivial values, two-entry queue
// depends on sfm_pkg
`default_nettype none
module sfm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire sfm_pkg::value_t query_value,
	output logic                 item_valid,
	output sfm_pkg::item_t       item,
	input  wire logic            item_pop
);
	import sfm_pkg::*;

	item_t       slot_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic        push;

	assign in_stall   = count_q == 2'd2;
	assign push       = in_valid && !in_stall;
	assign item_valid = count_q != 2'd0;
	assign item       = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (item_pop) rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, item_pop};
		end
	end

	// zero and one both answer 0
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q].value   <= query_value;
			slot_q[wptr_q].trivial <= query_value <= value_t'(1);
		end
	end
endmodule
`default_nettype wire

>>> rtl/sfm_engine.sv
// back part: trial-division factoring and legendre candidate search
// depends on sfm_pkg and sfm_div
`default_nettype none
module sfm_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire sfm_pkg::item_t item,
	output logic                item_pop,
	output sfm_pkg::res_t       res,
	input  wire logic           res_take
);
	import sfm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_HALF, S_FACT, S_LEFT, S_INIT, S_SDIV, S_SMUL, S_SCHK
	} state_t;
	state_t state_q;
	logic   done_st_q;

	value_t               rem_q, d_q, largest_q, m_q, mp_q, p_q;
	logic [EXP_W-1:0]     c_q, e_q;
	logic                 inner_q, first_q;
	value_t               pt_q [MAX_PRIMES];
	logic [EXP_W-1:0]     et_q [MAX_PRIMES];
	logic [CNT_W-1:0]     cnt_q, i_q;
	logic [VALUE_WIDTH:0] pw_q, sum_q, nsum;
	logic [2*VALUE_WIDTH-1:0] prod;
	value_t               mp_now;
	div_req_t             req_q;
	div_rsp_t             rsp;

	sfm_div u_div (.clk(clk), .arst_n(arst_n), .req(req_q), .rsp(rsp));

	assign item_pop  = state_q == S_IDLE && !done_st_q && item_valid;
	assign res.valid = done_st_q;
	assign res.value = m_q;
	assign nsum      = sum_q + {1'b0, rsp.quot};
	assign mp_now    = first_q ? rsp.quot : mp_q;
	assign prod      = pw_q[VALUE_WIDTH-1:0] * p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_st_q <= 1'b0;
			req_q     <= '0;
			cnt_q     <= '0;
			i_q       <= '0;
			largest_q <= '0;
			m_q       <= '0;
		end else begin
			req_q.start <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (done_st_q) begin
						if (res_take) done_st_q <= 1'b0;
					end else if (item_valid) begin
						cnt_q     <= '0;
						largest_q <= '0;
						rem_q     <= item.value;
						c_q       <= '0;
						if (item.trivial) begin
							m_q       <= '0;
							done_st_q <= 1'b1;
						end else begin
							state_q <= S_HALF;
						end
					end
				end
				S_HALF: begin
					if (!rem_q[0]) begin
						rem_q <= rem_q >> 1;
						c_q   <= c_q + 1'b1;
					end else begin
						if (c_q != '0) begin
							pt_q[0]   <= value_t'(2);
							et_q[0]   <= c_q;
							cnt_q     <= CNT_W'(1);
							largest_q <= value_t'(2);
						end
						d_q     <= value_t'(3);
						c_q     <= '0;
						inner_q <= 1'b0;
						req_q   <= '{start: 1'b1, dividend: rem_q, divisor: value_t'(3)};
						state_q <= S_FACT;
					end
				end
				S_FACT: begin
					if (rsp.done) begin
						if (!inner_q && d_q > rsp.quot) begin
							state_q <= S_LEFT;
						end else if (rsp.rem == '0) begin
							inner_q <= 1'b1;
							c_q     <= c_q + 1'b1;
							rem_q   <= rsp.quot;
							req_q   <= '{start: 1'b1, dividend: rsp.quot, divisor: d_q};
						end else begin
							if (inner_q) begin
								if (cnt_q < CNT_W'(MAX_PRIMES)) begin
									pt_q[cnt_q[IDX_W-1:0]] <= d_q;
									et_q[cnt_q[IDX_W-1:0]] <= c_q;
									cnt_q <= cnt_q + 1'b1;
								end
								largest_q <= d_q;
							end
							inner_q <= 1'b0;
							c_q     <= '0;
							d_q     <= d_q + value_t'(2);
							req_q   <= '{start: 1'b1, dividend: rem_q,
								divisor: d_q + value_t'(2)};
						end
					end
				end
				S_LEFT: begin
					// leftover cofactor above one is a prime
					if (rem_q > value_t'(1)) begin
						if (cnt_q < CNT_W'(MAX_PRIMES)) begin
							pt_q[cnt_q[IDX_W-1:0]] <= rem_q;
							et_q[cnt_q[IDX_W-1:0]] <= EXP_W'(1);
							cnt_q <= cnt_q + 1'b1;
						end
						largest_q <= rem_q;
						m_q       <= rem_q;
					end else begin
						m_q <= largest_q;
					end
					i_q     <= '0;
					state_q <= S_INIT;
				end
				S_INIT: begin
					if (i_q == cnt_q) begin
						done_st_q <= 1'b1;
						state_q   <= S_IDLE;
					end else if (pt_q[i_q[IDX_W-1:0]] > m_q) begin
						m_q <= m_q + 1'b1;
						i_q <= '0;
					end else begin
						p_q     <= pt_q[i_q[IDX_W-1:0]];
						e_q     <= et_q[i_q[IDX_W-1:0]];
						pw_q    <= {1'b0, pt_q[i_q[IDX_W-1:0]]};
						sum_q   <= '0;
						first_q <= 1'b1;
						req_q   <= '{start: 1'b1, dividend: m_q,
							divisor: pt_q[i_q[IDX_W-1:0]]};
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (rsp.done) begin
						if (nsum >= {{(VALUE_WIDTH+1-EXP_W){1'b0}}, e_q}) begin
							i_q     <= i_q + 1'b1;
							state_q <= S_INIT;
						end else if (pw_q > {1'b0, mp_now}) begin
							m_q     <= m_q + 1'b1;
							i_q     <= '0;
							state_q <= S_INIT;
						end else begin
							sum_q   <= nsum;
							mp_q    <= mp_now;
							first_q <= 1'b0;
							state_q <= S_SMUL;
						end
					end
				end
				S_SMUL: begin
					pw_q    <= prod[VALUE_WIDTH:0];
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (pw_q <= {1'b0, m_q}) begin
						req_q   <= '{start: 1'b1, dividend: m_q,
							divisor: pw_q[VALUE_WIDTH-1:0]};
						state_q <= S_SDIV;
					end else begin
						m_q     <= m_q + 1'b1;
						i_q     <= '0;
						state_q <= S_INIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_q.start |-> !rsp.busy) else $error("divider started while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PRIMES)) else $error("prime count beyond table");
	a_cand_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> m_q >= largest_q) else $error("candidate below largest prime");
`endif
endmodule
`default_nettype wire

>>> rtl/smallest_factorial_multiple_top.sv
// top level of the smallest factorial multiple (kempner function) block
// depends on sfm_pkg, sfm_queue, sfm_engine
`default_nettype none
// usage:
// - input channel: query_value with in_valid / in_stall; a word is taken at a
//   rising edge with in_valid high and in_stall low
// - output channel: least_factorial_base with out_valid / out_stall, one result
//   word per input word, in order
// - a two-entry queue in front takes words while the engine is busy
// - the engine factors by trial division through one serial divider
//   (up to sqrt of the value / 2 trial divisors), then walks candidates up
//   from the largest prime, each legendre term costing one divide plus a
//   multiply step; query values 0 and 1 answer 0 without factoring
// - latency is data dependent; the slowest words are squares of primes near
//   2^16: trial division up to the prime, then a check of each candidate up
//   to twice the prime; one item is worked on at a time, and the engine takes
//   no new word until its result has passed to the output register
// - the output register holds a word while out_stall is high; the engine then
//   waits with its finished result and the queue keeps filling
// - reset (arst_n low) empties queue and output register and idles the engine
module smallest_factorial_multiple_top (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire sfm_pkg::value_t query_value,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output sfm_pkg::value_t      least_factorial_base
);
	import sfm_pkg::*;

	logic   item_valid;
	item_t  item;
	logic   item_pop;
	res_t   res;
	logic   res_take;
	logic   out_valid_q;
	value_t out_data_q;

	// front: accept and classify
	sfm_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .query_value(query_value),
		.item_valid(item_valid), .item(item), .item_pop(item_pop)
	);

	// back: factor and search
	sfm_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item(item), .item_pop(item_pop),
		.res(res), .res_take(res_take)
	);

	// output register frees when empty or being taken
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res.valid) out_data_q <= res.value;
	end

	assign out_valid            = out_valid_q;
	assign least_factorial_base = out_data_q;
endmodule
`default_nettype wire
